[src/hdpr_pkg.sv]
`default_nettype none

package hdpr_pkg;

   // Line store geometry and pixel format.
   localparam int MAX_LINE_PIXELS = 16384;
   localparam int PIXEL_BYTES     = 3;
   localparam int PIXEL_W         = 24;
   localparam int BANK_ADDR_W     = $clog2(MAX_LINE_PIXELS);
   localparam int STORE_DEPTH     = 2 * MAX_LINE_PIXELS;
   localparam int STORE_ADDR_W    = $clog2(STORE_DEPTH);

   // Widths of the configuration registers and counters.
   localparam int SHIFT_W   = 2;
   localparam int WIDTH_W   = 15;
   localparam int COLUMN_W  = 14;
   localparam int GROUP_W   = 4;
   localparam int INDEX_W   = 15;
   localparam int CSR_IDX_W = 1;

   // Only the low bytes of a pixel that the format carries are kept.
   localparam logic [PIXEL_W-1:0] PIXEL_MASK =
      PIXEL_W'((33'd1 << (8 * PIXEL_BYTES)) - 33'd1);

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_INTERLEAVE_SHIFT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_PIXELS      = 1'd1;

   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 2'd0;
   localparam logic [WIDTH_W-1:0] WIDTH_RESET = 15'd32;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_in;
      logic               has_pixel;
   } req_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_out;
      logic               end_of_line;
   } rsp_type;

endpackage

`default_nettype wire

[src/hdpr_ram.sv]
`default_nettype none

module hdpr_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // One write port and one read port with a registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

[src/high_dpi_line_pixel_reorder.sv]
// A result leaves in the cycle after the item that reads it out is accepted.
// One item per cycle when not stalled; the store has one write and one read port.
// An item that reads out a pixel waits only while the output holds a stalled item.
// Reset clears the counters, the bank select and the pending-line flag and
// restores the registers to shift 0 and 32 pixels; the line store is not cleared.
`default_nettype none

module high_dpi_line_pixel_reorder
   import hdpr_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_write,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [WIDTH_W-1:0]   csr_wdata
);

   logic [SHIFT_W-1:0]  shift_ff;
   logic [WIDTH_W-1:0]  width_ff;
   logic                bank_ff,    bank_in;
   logic [COLUMN_W-1:0] column_ff,  column_in;
   logic [GROUP_W-1:0]  group_ff,   group_in;
   logic [INDEX_W-1:0]  index_ff,   index_in;
   logic                pending_ff, pending_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                eol_ff;
   logic                zero_ff;

   logic [WIDTH_W-1:0]      width_clamp;
   logic [WIDTH_W-1:0]      cols;
   logic [WIDTH_W-1:0]      eff;
   logic [GROUP_W:0]        factor;
   logic                    accept;
   logic                    emit;
   logic                    last;
   logic                    store_pixel;
   logic                    column_wrap;
   logic                    group_wrap;
   logic [COLUMN_W+3:0]     position;
   logic                    wr_en;
   logic [STORE_ADDR_W-1:0] wr_addr;
   logic [STORE_ADDR_W-1:0] rd_addr;
   logic [PIXEL_W-1:0]      rd_data;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= SHIFT_RESET;
         width_ff <= WIDTH_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_INTERLEAVE_SHIFT: shift_ff <= csr_wdata[SHIFT_W-1:0];
            CSR_LINE_PIXELS:      width_ff <= csr_wdata;
            default:              ;
         endcase
      end
   end

   // Line geometry: columns per group and the effective width.
   always_comb begin
      width_clamp = (width_ff > WIDTH_W'(MAX_LINE_PIXELS)) ?
                    WIDTH_W'(MAX_LINE_PIXELS) : width_ff;
      cols        = width_clamp >> shift_ff;
      eff         = cols << shift_ff;
      factor      = (GROUP_W+1)'(1) << shift_ff;
   end

   // Handshake: only an item that reads out a pixel needs room at the output.
   assign req_stall = rsp_valid_ff && rsp_stall && pending_ff;
   assign accept    = req_valid && !req_stall;
   assign emit      = accept && pending_ff;
   assign last      = ({1'b0, index_ff} + (INDEX_W+1)'(1)) >= {1'b0, eff};

   // Store position n * column + group, and the counter wrap tests.
   always_comb begin
      store_pixel = req_data.has_pixel && (cols != '0);
      column_wrap = ({1'b0, column_ff} + (COLUMN_W+1)'(1)) >= cols;
      group_wrap  = ({1'b0, group_ff} + (GROUP_W+1)'(1)) >= factor;
      position    = ({4'd0, column_ff} << shift_ff) + (COLUMN_W+4)'(group_ff);
      wr_en       = accept && store_pixel &&
                    (position[COLUMN_W+3:BANK_ADDR_W] == '0);
      wr_addr     = {bank_ff, position[BANK_ADDR_W-1:0]};
      rd_addr     = {~bank_ff, index_ff[BANK_ADDR_W-1:0]};
   end

   // Next state: read-out step first, then the write, then a bank swap.
   always_comb begin
      bank_in    = bank_ff;
      column_in  = column_ff;
      group_in   = group_ff;
      index_in   = index_ff;
      pending_in = pending_ff;
      if (emit) begin
         if (last) begin
            pending_in = 1'b0;
            index_in   = '0;
         end else begin
            index_in = index_ff + INDEX_W'(1);
         end
      end
      if (accept && store_pixel) begin
         if (column_wrap) begin
            column_in = '0;
            if (group_wrap) begin
               group_in   = '0;
               bank_in    = ~bank_ff;
               index_in   = '0;
               pending_in = 1'b1;
            end else begin
               group_in = group_ff + GROUP_W'(1);
            end
         end else begin
            column_in = column_ff + COLUMN_W'(1);
         end
      end
   end

   // The output holds its item until it is taken.
   assign rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff      <= 1'b0;
         column_ff    <= '0;
         group_ff     <= '0;
         index_ff     <= '0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bank_ff      <= bank_in;
         column_ff    <= column_in;
         group_ff     <= group_in;
         index_ff     <= index_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Side information that travels with the pixel read from the store.
   always_ff @(posedge clock) begin
      if (emit) begin
         eol_ff  <= last;
         zero_ff <= index_ff[INDEX_W-1:BANK_ADDR_W] != '0;
      end
   end

   // Two banks of the line store, one written and one read out.
   hdpr_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data.pixel_in & PIXEL_MASK),
      .rd_en   (emit),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_data.pixel_out   = zero_ff ? '0 : rd_data;
   assign rsp_data.end_of_line = eol_ff;

endmodule

`default_nettype wire

[src/hdpr_checker.sv]
`default_nettype none

module hdpr_checker
   import hdpr_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // A stalled result item stays and keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result item changed");

   // Reset leaves no result item pending.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result item present after reset");

   // A new result item appears only after an accepted input item.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !(req_valid && !req_stall) |=> !rsp_valid)
      else $error("result item without an accepted input item");

   // The input side waits only behind a stalled result item.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled while the output is free");

endmodule

bind high_dpi_line_pixel_reorder hdpr_checker u_hdpr_checker (.*);

`default_nettype wire
